// ===== rtl/hcao_pkg.sv =====
// Shared types, constants and arithmetic helpers for the hardware cursor overlay.
package hcao_pkg;

  // Frame coordinates at or beyond this bound never show the cursor.
  localparam int FRAME_MAX_DIM = 4096;

  localparam int COORD_W = 12;
  localparam int PIXEL_W = 32;
  localparam int DIM_W   = 7;
  localparam int CFG_W   = 12;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ENABLE = 3'd0,
    CFG_LEFT   = 3'd1,
    CFG_TOP    = 3'd2,
    CFG_COLS   = 3'd3,
    CFG_ROWS   = 3'd4
  } cfg_idx_t;

  // Transaction function codes.
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_t;

  // Window decode results for one input transaction.
  typedef struct packed {
    logic load_ok;    // cursor load lands inside the configured cursor size
    logic in_cursor;  // frame pixel falls inside the enabled cursor rectangle
  } hcao_win_t;

  // Exact floor(v / 255) for any v up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    begin
      t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
      return t[15:8];
    end
  endfunction

endpackage

// ===== rtl/hcao_ram.sv =====
// Generic single-port-write, registered-read RAM.
module hcao_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/hcao_window.sv =====
// Cursor window decode and cursor store address generation.
module hcao_window #(
  parameter int CURSOR_MAX_DIM = 64
) (
  input  logic                               func,
  input  logic [hcao_pkg::COORD_W-1:0]       pixel_x,
  input  logic [hcao_pkg::COORD_W-1:0]       pixel_y,
  input  logic                               cursor_enable,
  input  logic [hcao_pkg::COORD_W-1:0]       cursor_left,
  input  logic [hcao_pkg::COORD_W-1:0]       cursor_top,
  input  logic [hcao_pkg::DIM_W-1:0]         cursor_cols,
  input  logic [hcao_pkg::DIM_W-1:0]         cursor_rows,
  output hcao_pkg::hcao_win_t                win,
  output logic [(CURSOR_MAX_DIM * CURSOR_MAX_DIM > 1 ?
                 $clog2(CURSOR_MAX_DIM * CURSOR_MAX_DIM) : 1)-1:0] addr
);
  import hcao_pkg::*;

  localparam int DEPTH = CURSOR_MAX_DIM * CURSOR_MAX_DIM;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW    = CURSOR_MAX_DIM > 1 ? $clog2(CURSOR_MAX_DIM) : 1;
  localparam int DW    = $clog2(CURSOR_MAX_DIM + 1);

  logic [DW-1:0]      cols_sat;
  logic [DW-1:0]      rows_sat;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [CW-1:0]      col_sel;
  logic [CW-1:0]      row_sel;
  logic               in_frame;
  logic               past_corner;

  // Effective cursor size saturates at the store dimension.
  always_comb begin
    cols_sat = (32'(cursor_cols) > CURSOR_MAX_DIM) ? DW'(CURSOR_MAX_DIM) : DW'(cursor_cols);
    rows_sat = (32'(cursor_rows) > CURSOR_MAX_DIM) ? DW'(CURSOR_MAX_DIM) : DW'(cursor_rows);
  end

  // Offsets of a frame pixel from the cursor corner.
  assign dx          = pixel_x - cursor_left;
  assign dy          = pixel_y - cursor_top;
  assign in_frame    = (32'(pixel_x) < FRAME_MAX_DIM) && (32'(pixel_y) < FRAME_MAX_DIM);
  assign past_corner = (pixel_x >= cursor_left) && (pixel_y >= cursor_top);

  // Window checks for loads and frame pixels.
  always_comb begin
    win.load_ok   = (32'(pixel_x) < 32'(cols_sat)) && (32'(pixel_y) < 32'(rows_sat));
    win.in_cursor = cursor_enable && in_frame && past_corner &&
                    (32'(dx) < 32'(cols_sat)) && (32'(dy) < 32'(rows_sat));
  end

  // Store address is row * CURSOR_MAX_DIM + column; only meaningful inside the window.
  always_comb begin
    if (func == FUNC_LOAD) begin
      col_sel = pixel_x[CW-1:0];
      row_sel = pixel_y[CW-1:0];
    end else begin
      col_sel = dx[CW-1:0];
      row_sel = dy[CW-1:0];
    end
    addr = AW'(32'(row_sel) * CURSOR_MAX_DIM + 32'(col_sel));
  end

endmodule

// ===== rtl/hcao_blend.sv =====
// Per-byte alpha blend of a cursor pixel over a frame pixel, with BGRA to RGBA swap.
module hcao_blend (
  input  logic                        in_cursor,
  input  logic [hcao_pkg::PIXEL_W-1:0] frame_word,
  input  logic [hcao_pkg::PIXEL_W-1:0] cursor_word,
  output logic [hcao_pkg::PIXEL_W-1:0] result
);
  import hcao_pkg::*;

  logic [7:0]         alpha;
  logic [7:0]         inv_alpha;
  logic [PIXEL_W-1:0] mixed;
  logic [15:0]        sum [3];

  assign alpha     = cursor_word[31:24];
  assign inv_alpha = 8'hff - alpha;

  // Blend each colour byte; the frame alpha byte passes through.
  always_comb begin
    mixed[31:24] = frame_word[31:24];
    for (int i = 0; i < 3; i++) begin
      sum[i] = 16'(frame_word[8*i +: 8] * inv_alpha) + 16'(cursor_word[8*i +: 8] * alpha);
      if (!in_cursor || alpha == 8'h00) begin
        mixed[8*i +: 8] = frame_word[8*i +: 8];
      end else if (alpha == 8'hff) begin
        mixed[8*i +: 8] = cursor_word[8*i +: 8];
      end else begin
        mixed[8*i +: 8] = div255(sum[i]);
      end
    end
  end

  // Swap bytes 0 and 2.
  assign result = {mixed[31:24], mixed[7:0], mixed[15:8], mixed[23:16]};

endmodule

// ===== rtl/hw_cursor_alpha_overlay.sv =====
// Hardware cursor overlay top level: config registers, cursor store and output pipeline.
// A frame pixel passes stage 1 (store read), then the output register, to out_pixel.
// Throughput: one transaction per cycle while out_ready is high; the cursor store's
// registered read port sets the two-stage pipeline.
// Cursor loads produce no output transaction.
// Reset (synchronous, rst_n low) clears the pipeline and all config registers;
// cursor store contents are undefined until written.
module hw_cursor_alpha_overlay #(
  parameter int CURSOR_MAX_DIM = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [2:0]                   cfg_index,
  input  logic [hcao_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [hcao_pkg::COORD_W-1:0] in_pixel_x,
  input  logic [hcao_pkg::COORD_W-1:0] in_pixel_y,
  input  logic [hcao_pkg::PIXEL_W-1:0] in_pixel_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hcao_pkg::PIXEL_W-1:0] out_pixel
);
  import hcao_pkg::*;

  localparam int DEPTH = CURSOR_MAX_DIM * CURSOR_MAX_DIM;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic               cursor_enable_r;
  logic [COORD_W-1:0] cursor_left_r;
  logic [COORD_W-1:0] cursor_top_r;
  logic [DIM_W-1:0]   cursor_cols_r;
  logic [DIM_W-1:0]   cursor_rows_r;

  hcao_win_t          win;
  logic [AW-1:0]      store_addr;
  logic [PIXEL_W-1:0] cursor_word;
  logic               in_xfer;
  logic               ram_wr_en;
  logic               ram_rd_en;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic               s1_hit_r;
  logic [PIXEL_W-1:0] s1_word_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [PIXEL_W-1:0] out_pixel_r;
  logic [PIXEL_W-1:0] blend_result;
  logic               out_free;
  logic               s1_move;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_enable_r <= 1'b0;
      cursor_left_r   <= '0;
      cursor_top_r    <= '0;
      cursor_cols_r   <= '0;
      cursor_rows_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: cursor_enable_r <= cfg_wdata[0];
        CFG_LEFT:   cursor_left_r   <= cfg_wdata[COORD_W-1:0];
        CFG_TOP:    cursor_top_r    <= cfg_wdata[COORD_W-1:0];
        CFG_COLS:   cursor_cols_r   <= cfg_wdata[DIM_W-1:0];
        CFG_ROWS:   cursor_rows_r   <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Window decode of the incoming transaction.
  hcao_window #(
    .CURSOR_MAX_DIM(CURSOR_MAX_DIM)
  ) u_window (
    .func          (in_func),
    .pixel_x       (in_pixel_x),
    .pixel_y       (in_pixel_y),
    .cursor_enable (cursor_enable_r),
    .cursor_left   (cursor_left_r),
    .cursor_top    (cursor_top_r),
    .cursor_cols   (cursor_cols_r),
    .cursor_rows   (cursor_rows_r),
    .win           (win),
    .addr          (store_addr)
  );

  // Handshake: stage 1 empties into the output register whenever that register is free.
  assign out_free  = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_xfer   = in_valid && in_ready;
  assign ram_wr_en = in_xfer && (in_func == FUNC_LOAD) && win.load_ok;
  assign ram_rd_en = in_xfer && (in_func == FUNC_PIXEL);

  // Cursor store.
  hcao_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (store_addr),
    .wr_data (in_pixel_word),
    .rd_en   (ram_rd_en),
    .rd_addr (store_addr),
    .rd_data (cursor_word)
  );

  // Stage 1 holds the frame pixel while the store read completes.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (ram_rd_en) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_rd_en) begin
      s1_hit_r  <= win.in_cursor;
      s1_word_r <= in_pixel_word;
    end
  end

  // Blend and byte swap.
  hcao_blend u_blend (
    .in_cursor   (s1_hit_r),
    .frame_word  (s1_word_r),
    .cursor_word (cursor_word),
    .result      (blend_result)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pixel_r <= blend_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  // A store read is always followed by a pixel occupying stage 1.
  a_read_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    ram_rd_en |=> s1_valid_r)
    else $error("store read without stage 1 pixel");

  // The store is never written and read in the same cycle.
  a_no_wr_rd: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr_en && ram_rd_en))
    else $error("store written and read together");

  // A stalled stage 1 keeps its pixel and its read data.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> (s1_valid_r && $stable(cursor_word)))
    else $error("stage 1 lost data under stall");

  // A result leaves only when taken.
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready))
    else $error("result dropped without handshake");

endmodule

// ===== verif/hcao_checker.sv =====
// Checker for the cursor overlay: watches both channels, predicts each result pixel and compares.
`timescale 1ns / 100ps

module hcao_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [2:0]                   cfg_index,
  input  logic [hcao_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_func,
  input  logic [hcao_pkg::COORD_W-1:0] in_pixel_x,
  input  logic [hcao_pkg::COORD_W-1:0] in_pixel_y,
  input  logic [hcao_pkg::PIXEL_W-1:0] in_pixel_word,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [hcao_pkg::PIXEL_W-1:0] out_pixel,
  output int unsigned                  mismatch_count,
  output int unsigned                  pending_pixels
);
  import hcao_pkg::*;

  localparam int CUR_DIM = 64;

  // Shadow copy of the configuration and of the cursor store.
  logic                 en_q;
  logic [COORD_W-1:0]   left_q;
  logic [COORD_W-1:0]   top_q;
  logic [DIM_W-1:0]     cols_q;
  logic [DIM_W-1:0]     rows_q;
  logic [PIXEL_W-1:0]   cursor_mem [CUR_DIM*CUR_DIM];
  logic [PIXEL_W-1:0]   blended_q [$];
  logic [PIXEL_W-1:0]   want_pixel;

  // Width or height in use, saturated to the store's dimension.
  function automatic int unsigned dim_limit(logic [DIM_W-1:0] d);
    return (d > CUR_DIM) ? CUR_DIM : int'(d);
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] f, logic [7:0] c, logic [7:0] a);
    int unsigned fi, ci, ai;
    fi = f;
    ci = c;
    ai = a;
    return 8'((fi * (255 - ai) + ci * ai) / 255);
  endfunction

  // Composite the cursor over one frame pixel, then swap BGRA into RGBA.
  function automatic logic [PIXEL_W-1:0] overlay_pixel(logic [COORD_W-1:0] x,
                                                       logic [COORD_W-1:0] y,
                                                       logic [PIXEL_W-1:0] frame);
    int unsigned dx, dy;
    logic [PIXEL_W-1:0] cur, r;
    logic [7:0] a;
    r = frame;
    if (en_q && x >= left_q && y >= top_q) begin
      dx = x - left_q;
      dy = y - top_q;
      if (dx < dim_limit(cols_q) && dy < dim_limit(rows_q)) begin
        cur = cursor_mem[dy * CUR_DIM + dx];
        a = cur[31:24];
        if (a != 8'h00) begin
          for (int b = 0; b < 3; b++) begin
            r[b*8 +: 8] = (a == 8'hff) ? cur[b*8 +: 8] :
                          mix_channel(frame[b*8 +: 8], cur[b*8 +: 8], a);
          end
        end
      end
    end
    return {r[31:24], r[7:0], r[15:8], r[23:16]};
  endfunction

  initial begin
    mismatch_count = 0;
    pending_pixels = 0;
    for (int i = 0; i < CUR_DIM * CUR_DIM; i++) cursor_mem[i] = '0;
  end

  // Result transactions are checked before this edge's input is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      en_q   = 1'b0;
      left_q = '0;
      top_q  = '0;
      cols_q = '0;
      rows_q = '0;
      blended_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (blended_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected out_pixel %08h with nothing pending", $time, out_pixel);
          mismatch_count++;
        end else begin
          want_pixel = blended_q.pop_front();
          if (out_pixel !== want_pixel) begin
            if (mismatch_count < 10)
              $display("%0t: out_pixel mismatch: expected %08h, got %08h",
                       $time, want_pixel, out_pixel);
            mismatch_count++;
          end
        end
      end

      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENABLE: en_q   = cfg_wdata[0];
          CFG_LEFT:   left_q = cfg_wdata[COORD_W-1:0];
          CFG_TOP:    top_q  = cfg_wdata[COORD_W-1:0];
          CFG_COLS:   cols_q = cfg_wdata[DIM_W-1:0];
          CFG_ROWS:   rows_q = cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (func_t'(in_func) == FUNC_LOAD) begin
          if (in_pixel_x < dim_limit(cols_q) && in_pixel_y < dim_limit(rows_q))
            cursor_mem[in_pixel_y * CUR_DIM + in_pixel_x] = in_pixel_word;
        end else begin
          blended_q.push_back(overlay_pixel(in_pixel_x, in_pixel_y, in_pixel_word));
        end
      end
    end
    pending_pixels = blended_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Testbench top for the cursor overlay: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module testbench;
  import hcao_pkg::*;

  localparam int CUR_DIM  = 64;
  localparam int STALL_AT = 1450;
  localparam int STALL_CYCLES = 80;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [2:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                in_func;
  logic [COORD_W-1:0]  in_pixel_x;
  logic [COORD_W-1:0]  in_pixel_y;
  logic [PIXEL_W-1:0]  in_pixel_word;
  logic                out_valid;
  logic                out_ready;
  logic [PIXEL_W-1:0]  out_pixel;

  int unsigned mismatch_count;
  int unsigned pending_pixels;

  // Stimulus-side view of the configuration and of which store entries hold data.
  bit  cur_en;
  int  cur_left, cur_top, eff_cols, eff_rows;
  bit  cursor_loaded [CUR_DIM*CUR_DIM];
  int  items_sent;
  bit  stall_req, stall_done;

  hw_cursor_alpha_overlay dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .in_pixel_word(in_pixel_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel    (out_pixel)
  );

  hcao_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_pixel_word (in_pixel_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel     (out_pixel),
    .mismatch_count(mismatch_count),
    .pending_pixels(pending_pixels)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #2000000;
    $display("hw_cursor_alpha_overlay test failed");
    $finish;
  end

  // Idle pattern: receiver-heavy, then sender-heavy, then none.
  function automatic int idle_phase();
    if (items_sent < 650) return 0;
    if (items_sent < 1300) return 1;
    return 2;
  endfunction

  function automatic bit sender_idles();
    case (idle_phase())
      0:       return $urandom_range(99) < 21;
      1:       return $urandom_range(99) < 66;
      default: return 1'b0;
    endcase
  endfunction

  // Result side: random back-pressure plus one long hold-off to fill the block.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req && !stall_done) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        stall_done = 1'b1;
      end else begin
        case (idle_phase())
          0:       out_ready <= ($urandom_range(99) >= 66);
          1:       out_ready <= ($urandom_range(99) >= 21);
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  // Offer one transaction and hold it until the block takes it.
  task automatic send_txn(func_t f, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                          logic [PIXEL_W-1:0] w);
    @(negedge clk);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_pixel_x    <= x;
    in_pixel_y    <= y;
    in_pixel_word <= w;
    items_sent++;
    if (items_sent == STALL_AT) stall_req = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [PIXEL_W-1:0] pick_cursor_word();
    logic [PIXEL_W-1:0] w;
    w = $urandom;
    case ($urandom_range(3))
      0:       w[31:24] = 8'h00;
      1:       w[31:24] = 8'hff;
      default: ;
    endcase
    return w;
  endfunction

  task automatic load_cursor(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [PIXEL_W-1:0] w);
    send_txn(FUNC_LOAD, x, y, w);
    if (x < eff_cols && y < eff_rows) cursor_loaded[y * CUR_DIM + x] = 1'b1;
  endtask

  // A pixel over a store entry that was never loaded gets that entry loaded first.
  task automatic send_frame_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [PIXEL_W-1:0] w);
    int dx, dy;
    if (cur_en && x >= cur_left && y >= cur_top) begin
      dx = x - cur_left;
      dy = y - cur_top;
      if (dx < eff_cols && dy < eff_rows && !cursor_loaded[dy * CUR_DIM + dx])
        load_cursor(COORD_W'(dx), COORD_W'(dy), pick_cursor_word());
    end
    send_txn(FUNC_PIXEL, x, y, w);
  endtask

  // Registers change only once the block has drained.
  task automatic write_cursor_cfg(bit en, int left, int top, int cols, int rows);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_wdata <= CFG_W'(en);
    @(negedge clk);
    cfg_index <= CFG_LEFT;
    cfg_wdata <= CFG_W'(left);
    @(negedge clk);
    cfg_index <= CFG_TOP;
    cfg_wdata <= CFG_W'(top);
    @(negedge clk);
    cfg_index <= CFG_COLS;
    cfg_wdata <= CFG_W'(cols);
    @(negedge clk);
    cfg_index <= CFG_ROWS;
    cfg_wdata <= CFG_W'(rows);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_en   = en;
    cur_left = left;
    cur_top  = top;
    eff_cols = (cols > CUR_DIM) ? CUR_DIM : cols;
    eff_rows = (rows > CUR_DIM) ? CUR_DIM : rows;
  endtask

  // Mostly loads and pixels around the cursor rectangle, some anywhere.
  task automatic run_random(int n);
    int r;
    logic [COORD_W-1:0] x, y;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 30) begin
        if ($urandom_range(9) == 0) begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end else begin
          x = COORD_W'($urandom_range(eff_cols + 3));
          y = COORD_W'($urandom_range(eff_rows + 3));
        end
        load_cursor(x, y, pick_cursor_word());
      end else begin
        if (r < 85) begin
          x = COORD_W'(cur_left + $urandom_range(eff_cols + 8) - 4);
          y = COORD_W'(cur_top + $urandom_range(eff_rows + 8) - 4);
        end else begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end
        send_frame_pixel(x, y, $urandom);
      end
    end
  endtask

  initial begin
    int waited;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_ENABLE;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_func       = FUNC_LOAD;
    in_pixel_x    = '0;
    in_pixel_y    = '0;
    in_pixel_word = '0;
    items_sent    = 0;
    stall_req     = 1'b0;
    stall_done    = 1'b0;
    cur_en        = 1'b0;
    cur_left      = 0;
    cur_top       = 0;
    eff_cols      = 0;
    eff_rows      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset state: cursor off and empty, loads are dropped.
    send_frame_pixel(0, 0, 32'h11223344);
    load_cursor(0, 0, 32'hff0000ff);
    send_frame_pixel(12'hfff, 12'hfff, 32'hffffffff);
    send_frame_pixel(12'h555, 12'haaa, 32'h00000000);

    // Alpha of zero, full, mid, one and 254, plus the rectangle's edges.
    write_cursor_cfg(1, 10, 20, 12, 12);
    load_cursor(0, 0, 32'h00aabbcc);
    load_cursor(1, 0, 32'hff102030);
    load_cursor(2, 0, 32'h80ffffff);
    load_cursor(3, 0, 32'h01ff00ff);
    load_cursor(4, 0, 32'hfe00ff00);
    load_cursor(11, 11, 32'hffffffff);
    load_cursor(9, 0, 32'hff445566);
    send_frame_pixel(10, 20, 32'h12345678);
    send_frame_pixel(11, 20, 32'habcdef01);
    send_frame_pixel(12, 20, 32'hff000000);
    send_frame_pixel(12, 20, 32'h00ffffff);
    send_frame_pixel(13, 20, 32'h7f7f7f7f);
    send_frame_pixel(14, 20, 32'hffffffff);
    send_frame_pixel(21, 31, 32'h00000000);
    send_frame_pixel(22, 31, 32'h55aa55aa);
    send_frame_pixel(9, 20, 32'haa55aa55);
    send_frame_pixel(19, 20, 32'h01020304);

    // Shrunk cursor: loads past its size must not touch the store.
    write_cursor_cfg(1, 10, 20, 8, 8);
    load_cursor(9, 0, 32'h80000000);
    load_cursor(0, 9, 32'h80000000);
    send_frame_pixel(19, 20, 32'h01020304);

    // Grown again: the entry kept its earlier contents.
    write_cursor_cfg(1, 10, 20, 64, 64);
    send_frame_pixel(19, 20, 32'h00808080);
    run_random(160);

    write_cursor_cfg(1, 0, 0, 127, 127);
    run_random(180);
    write_cursor_cfg(1, 4095, 4095, 64, 64);
    run_random(170);
    write_cursor_cfg(1, 4060, 5, 40, 3);
    run_random(190);
    write_cursor_cfg(0, 300, 300, 64, 64);
    run_random(130);
    write_cursor_cfg(1, 2000, 1000, 0, 20);
    run_random(130);
    write_cursor_cfg(1, 37, 4000, 1, 1);
    run_random(130);
    write_cursor_cfg(1, 500, 600, 33, 17);
    run_random(180);
    write_cursor_cfg(1, 3000, 50, 100, 64);
    run_random(200);

    // Drain the remaining results, then allow for the pipeline depth.
    @(negedge clk);
    in_valid <= 1'b0;
    for (waited = 0; waited < 20000 && pending_pixels != 0; waited++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_pixels == 0)
      $display("hw_cursor_alpha_overlay test passed");
    else
      $display("hw_cursor_alpha_overlay test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hcao_pkg.sv
rtl/hcao_ram.sv
rtl/hcao_window.sv
rtl/hcao_blend.sv
rtl/hw_cursor_alpha_overlay.sv
verif/hcao_checker.sv
verif/testbench.sv
